// ===== rtl/core/rgb_to_xyz_converter_assert.svh =====
// Assertion macros shared by the converter RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef RGB_TO_XYZ_CONVERTER_ASSERT_SVH
`define RGB_TO_XYZ_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define RTXC_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtxc check failed");

// Implication after a fixed number of cycles.
`define RTXC_CHECK_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("rtxc delayed check failed");

`endif

// ===== rtl/core/rtxc_pkg.sv =====
package rtxc_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 8;
  localparam int LIN_BITS  = 16;
  localparam int CODE_W    = 8;
  localparam int LIN_W     = LIN_BITS + 1;
  localparam int OUT_W     = 15;
  localparam int OUT_MAX   = (1 << OUT_W) - 1;
  localparam int NUM_CODES = 1 << CODE_W;

  // Matrix coefficients, scaled by 10^7
  localparam int COEF_W = 24;
  localparam int PROD_W = 40;
  localparam int SUM_W  = 40;
  localparam logic [COEF_W-1:0] COEF [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };

  // Output scaling: q = floor((s + D/2) / D), D = 10^5 * 2^(LIN_BITS-FRAC_BITS)
  // D splits into 2^DEN_SHIFT * DIV_ODD with 10^5 = 2^5 * 3125.
  localparam int DIV_ODD   = 3125;
  localparam int DEN_SHIFT = LIN_BITS - FRAC_BITS + 5;
  localparam logic [SUM_W-1:0] RND_ADD = SUM_W'(DIV_ODD) << (DEN_SHIFT - 1);

  // Reciprocal of DIV_ODD, exact floor for any 27-bit dividend
  localparam int U_W         = 27;
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 39;
  localparam logic [RECIP_W-1:0] RECIP = 28'd175921861;
  localparam int MUL_W       = U_W + RECIP_W;
  localparam int QUO_W       = 16;

  // Pipeline depth from accepted request to result strobe
  localparam int PIPE_LAT = 5;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_SRGB_MODE = 1'b0;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] x_value;
    logic [OUT_W-1:0] y_value;
    logic [OUT_W-1:0] z_value;
  } pixel_out_t;

  typedef logic [LIN_W-1:0] lin_rom_t [NUM_CODES];
  typedef logic [2:0][LIN_W-1:0] lin_trip_t;
  typedef logic [2:0][U_W-1:0] u_trip_t;

  // Build the sRGB linearization table at elaboration
  function automatic lin_rom_t gen_srgb_rom();
    lin_rom_t rom;
    real      x;
    real      v;
    for (int c = 0; c < NUM_CODES; c++) begin
      if (c <= 10) begin
        rom[c] = LIN_W'(((c * 10) * (1 << LIN_BITS) + 16473) / 32946);
      end else begin
        x = real'(1000 * c + 14025) / 269025.0;
        v = (x ** 2.4) * real'(1 << LIN_BITS);
        rom[c] = LIN_W'($rtoi(v + 0.5));
      end
    end
    return rom;
  endfunction

  // Build the plain c/255 table at elaboration
  function automatic lin_rom_t gen_linear_rom();
    lin_rom_t rom;
    for (int c = 0; c < NUM_CODES; c++) begin
      rom[c] = LIN_W'(((c << LIN_BITS) + 127) / 255);
    end
    return rom;
  endfunction

  localparam lin_rom_t SRGB_ROM   = gen_srgb_rom();
  localparam lin_rom_t LINEAR_ROM = gen_linear_rom();

endpackage

// ===== rtl/core/rgb_to_xyz_converter.sv =====
// Throughput: one pixel per clock; busy stays low, so start may be high every cycle.
// Depth is set by the five-stage pipe: table lookup, products, row sums, reciprocal
// multiply, saturation. Results cannot be held off by the receiver.
// Reset (rst_n low, synchronous) clears all pipeline valid bits and sets srgb_mode to 1.
module rgb_to_xyz_converter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rtxc_pkg::pixel_in_t          in_data,
  output logic                         out_valid,
  output rtxc_pkg::pixel_out_t         out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtxc_pkg::CFG_AW-1:0]  paddr,
  input  logic [rtxc_pkg::CFG_DW-1:0]  pwdata,
  output logic [rtxc_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import rtxc_pkg::*;
  `include "rgb_to_xyz_converter_assert.svh"

  logic      srgb_mode;
  logic      accept;
  logic      lin_valid;
  lin_trip_t lin;
  logic      u_valid;
  u_trip_t   u;

  // Every stage advances each cycle, so a request is always taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rtxc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .srgb_mode (srgb_mode)
  );

  rtxc_lin u_lin (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (accept),
    .pix_in    (in_data),
    .srgb_mode (srgb_mode),
    .valid_out (lin_valid),
    .lin_out   (lin)
  );

  rtxc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (lin_valid),
    .lin_in    (lin),
    .valid_out (u_valid),
    .u_out     (u)
  );

  rtxc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (u_valid),
    .u_in      (u),
    .valid_out (out_valid),
    .pix_out   (out_data)
  );

  `RTXC_CHECK_DLY(a_result_follows, accept, PIPE_LAT, out_valid)
  `RTXC_CHECK_DLY(a_no_extra_result, !accept, PIPE_LAT, !out_valid)
  `RTXC_CHECK_DLY(a_black_is_zero, accept && (in_data == '0), PIPE_LAT, out_data == '0)
  `RTXC_CHECK(a_y_in_range, out_valid, out_data.y_value <= 15'd25600)

endmodule

// ===== rtl/core/rtxc_regs.sv =====
module rtxc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtxc_pkg::CFG_AW-1:0]  paddr,
  input  logic [rtxc_pkg::CFG_DW-1:0]  pwdata,
  output logic [rtxc_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output logic                         srgb_mode
);
  import rtxc_pkg::*;

  logic srgb_mode_r;
  logic wr_en;

  // No wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Update the mode bit on a completed write request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srgb_mode_r <= 1'b1;
    end else if (wr_en && (paddr[2] == REG_SRGB_MODE)) begin
      srgb_mode_r <= pwdata[0];
    end
  end

  // Return the register on reads, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SRGB_MODE) begin
      prdata = {{(CFG_DW-1){1'b0}}, srgb_mode_r};
    end
  end

  assign srgb_mode = srgb_mode_r;

endmodule

// ===== rtl/core/rtxc_lin.sv =====
module rtxc_lin (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_in,
  input  rtxc_pkg::pixel_in_t   pix_in,
  input  logic                  srgb_mode,
  output logic                  valid_out,
  output rtxc_pkg::lin_trip_t   lin_out
);
  import rtxc_pkg::*;

  logic      valid_r;
  lin_trip_t lin_r;
  lin_trip_t lin_nxt;
  logic [2:0][CODE_W-1:0] code;

  assign code = {pix_in.blue, pix_in.green, pix_in.red};

  // Look up each channel in the table the mode selects
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lin_nxt[k] = srgb_mode ? SRGB_ROM[code[k]] : LINEAR_ROM[code[k]];
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  // Hold the linear channels
  always_ff @(posedge clk) begin
    lin_r <= lin_nxt;
  end

  assign valid_out = valid_r;
  assign lin_out   = lin_r;

endmodule

// ===== rtl/core/rtxc_mac.sv =====
module rtxc_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_in,
  input  rtxc_pkg::lin_trip_t  lin_in,
  output logic                 valid_out,
  output rtxc_pkg::u_trip_t    u_out
);
  import rtxc_pkg::*;

  logic [2:0][2:0][PROD_W-1:0] prod_r;
  logic [2:0][2:0][PROD_W-1:0] prod_nxt;
  logic                        prod_valid_r;
  logic [2:0][SUM_W-1:0]       sum;
  u_trip_t                     u_r;
  u_trip_t                     u_nxt;
  logic                        u_valid_r;

  // Form the nine coefficient products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[r][k] = PROD_W'(COEF[r][k]) * PROD_W'(lin_in[k]);
      end
    end
  end

  // Add each row, add the rounding offset, drop the power-of-two part of the divisor
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r]   = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1])
               + SUM_W'(prod_r[r][2]) + RND_ADD;
      u_nxt[r] = sum[r][DEN_SHIFT +: U_W];
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      u_valid_r    <= 1'b0;
    end else begin
      prod_valid_r <= valid_in;
      u_valid_r    <= prod_valid_r;
    end
  end

  // Hold products and row sums
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    u_r    <= u_nxt;
  end

  assign valid_out = u_valid_r;
  assign u_out     = u_r;

endmodule

// ===== rtl/core/rtxc_scale.sv =====
module rtxc_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_in,
  input  rtxc_pkg::u_trip_t     u_in,
  output logic                  valid_out,
  output rtxc_pkg::pixel_out_t  pix_out
);
  import rtxc_pkg::*;

  logic [2:0][MUL_W-1:0] mul;
  logic [2:0][QUO_W-1:0] q_r;
  logic [2:0][QUO_W-1:0] q_nxt;
  logic                  q_valid_r;
  logic [2:0][OUT_W-1:0] sat;
  pixel_out_t            pix_r;
  pixel_out_t            pix_nxt;
  logic                  pix_valid_r;

  // Divide by the odd part of the divisor through its reciprocal
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mul[r]   = MUL_W'(u_in[r]) * MUL_W'(RECIP);
      q_nxt[r] = mul[r][RECIP_SHIFT +: QUO_W];
    end
  end

  // Saturate to the output width
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sat[r] = (q_r[r] > QUO_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : q_r[r][OUT_W-1:0];
    end
    pix_nxt.x_value = sat[0];
    pix_nxt.y_value = sat[1];
    pix_nxt.z_value = sat[2];
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r   <= 1'b0;
      pix_valid_r <= 1'b0;
    end else begin
      q_valid_r   <= valid_in;
      pix_valid_r <= q_valid_r;
    end
  end

  // Hold quotients and the result
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    pix_r <= pix_nxt;
  end

  assign valid_out = pix_valid_r;
  assign pix_out   = pix_r;

endmodule
